>>> rtl/lcdnw_pkg.sv
// ----------------------------------------------------------------------------
// LCD nibble writer package
// Shared operation codes, widths, constants and controller/datapath links.
// ----------------------------------------------------------------------------
package lcdnw_pkg;

  localparam int unsigned HOLD_W = 24;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 24'd100000;

  localparam logic [1:0] OP_CMD     = 2'd0;
  localparam logic [1:0] OP_DATA    = 2'd1;
  localparam logic [1:0] OP_CURSOR  = 2'd2;
  localparam logic [1:0] OP_POWERUP = 2'd3;

  localparam logic [7:0] LINE0_BASE = 8'h80;
  localparam logic [7:0] LINE1_BASE = 8'hC0;

  localparam logic [2:0] PWR_LAST_IDX = 3'd4;
  localparam logic [1:0] PHASE_LAST   = 2'd3;

  typedef struct packed {
    logic load;
    logic advance;
    logic count;
  } lcdnw_cmd_t;

  typedef struct packed {
    logic is_last;
    logic hold_done;
  } lcdnw_status_t;

  function automatic logic [7:0] powerup_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h33;
      3'd1: b = 8'h32;
      3'd2: b = 8'h28;
      3'd3: b = 8'h0C;
      3'd4: b = 8'h01;
      default: b = 8'h01;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/lcdnw_ctrl.sv
// ----------------------------------------------------------------------------
// LCD nibble writer controller
// Sequences accept, pin state output and hold timing for each item.
// ----------------------------------------------------------------------------
module lcdnw_ctrl
  import lcdnw_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  lcdnw_status_t status,
  output lcdnw_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EMIT = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.load    = 1'b0;
    cmd.advance = 1'b0;
    cmd.count   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.is_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        cmd.count = 1'b1;
        if (status.hold_done) begin
          state_next = S_EMIT;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/lcdnw_dp.sv
// ----------------------------------------------------------------------------
// LCD nibble writer datapath
// Holds the byte in flight, the pin phase, the hold counter and the register.
// ----------------------------------------------------------------------------
module lcdnw_dp
  import lcdnw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [HOLD_W-1:0] cfg_wdata,
  input  logic [1:0]        opcode,
  input  logic [7:0]        value,
  input  logic              row,
  input  logic [5:0]        col,
  input  lcdnw_cmd_t        cmd,
  output lcdnw_status_t     status,
  output logic              reg_select,
  output logic              enable,
  output logic [3:0]        nibble,
  output logic              last
);

  logic [HOLD_W-1:0] hold_cycles;
  logic [HOLD_W-1:0] count;
  logic              powerup;
  logic              rs;
  logic [2:0]        idx;
  logic [1:0]        phase;
  logic [7:0]        cur_byte;
  logic [7:0]        load_byte;
  logic [7:0]        cursor_addr;
  logic [2:0]        idx_next;

  assign cursor_addr = (row ? LINE1_BASE : LINE0_BASE) + {2'b00, col};
  assign idx_next    = idx + 3'd1;

  always_comb begin
    case (opcode)
      OP_CMD:     load_byte = value;
      OP_DATA:    load_byte = value;
      OP_CURSOR:  load_byte = cursor_addr;
      OP_POWERUP: load_byte = powerup_byte(3'd0);
      default:    load_byte = value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_cycles <= HOLD_RESET;
    end else if (cfg_we) begin
      hold_cycles <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rs       <= 1'b0;
      phase    <= 2'd0;
      cur_byte <= 8'h00;
      idx      <= 3'd0;
      powerup  <= 1'b0;
    end else if (cmd.load) begin
      rs       <= (opcode == OP_DATA);
      phase    <= 2'd0;
      cur_byte <= load_byte;
      idx      <= 3'd0;
      powerup  <= (opcode == OP_POWERUP);
    end else if (cmd.advance) begin
      phase <= phase + 2'd1;
      if (phase == PHASE_LAST) begin
        idx      <= idx_next;
        cur_byte <= powerup_byte(idx_next);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      count <= hold_cycles;
    end else if (cmd.count) begin
      count <= count - {{(HOLD_W-1){1'b0}}, 1'b1};
    end
  end

  assign reg_select = rs;
  assign enable     = ~phase[0];
  assign nibble     = phase[1] ? cur_byte[3:0] : cur_byte[7:4];
  assign last       = (phase == PHASE_LAST) && (!powerup || idx == PWR_LAST_IDX);

  assign status.is_last   = last;
  assign status.hold_done = (count <= {{(HOLD_W-1){1'b0}}, 1'b1});

endmodule

>>> rtl/char_lcd_nibble_writer.sv
// The first pin state is offered in the cycle after an item is accepted.
// Each later pin state is offered once the previous one is taken and the hold
// counter, loaded from hold_cycles when it is taken, has counted down to 1 or below.
// One item is in flight at a time; the next is accepted after its last pin state.
// Synchronous reset returns to idle and sets hold_cycles to 100000.
// ----------------------------------------------------------------------------
// Character LCD nibble writer
// Turns command, data, cursor and power-up operations into 4-bit pin states.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer
  import lcdnw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [HOLD_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        opcode,
  input  logic [7:0]        value,
  input  logic              row,
  input  logic [5:0]        col,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              reg_select,
  output logic              enable,
  output logic [3:0]        nibble,
  output logic              last
);

  lcdnw_cmd_t    cmd;
  lcdnw_status_t status;

  lcdnw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lcdnw_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .opcode     (opcode),
    .value      (value),
    .row        (row),
    .col        (col),
    .cmd        (cmd),
    .status     (status),
    .reg_select (reg_select),
    .enable     (enable),
    .nibble     (nibble),
    .last       (last)
  );

endmodule

>>> rtl/lcdnw_checker.sv
// ----------------------------------------------------------------------------
// LCD nibble writer checker
// Port-level properties of the writer, bound to the top level.
// ----------------------------------------------------------------------------
module lcdnw_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       reg_select,
  input logic       enable,
  input logic [3:0] nibble,
  input logic       last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(reg_select) && $stable(enable)
      && $stable(nibble) && $stable(last))
    else $error("pin state changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in flight");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a pin state is pending");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> in_ready && !out_valid)
    else $error("not idle after the final pin state");

  a_hold_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> !out_valid && !in_ready)
    else $error("pin state not held after it was taken");

endmodule

bind char_lcd_nibble_writer lcdnw_checker u_lcdnw_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .reg_select (reg_select),
  .enable     (enable),
  .nibble     (nibble),
  .last       (last)
);

>>> tb/sv/tb_char_lcd_nibble_writer.sv
// ----------------------------------------------------------------------------
// Character LCD nibble writer testbench
// Sends command, data, cursor and power-up items under several hold times,
// predicts every pin state each item must produce and checks them in order,
// with random idle bursts on the input side and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_writer
  import lcdnw_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_MAX = 10;
  localparam logic [7:0] POWERUP_SEQ [5] = '{8'h33, 8'h32, 8'h28, 8'h0C, 8'h01};
  localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

  typedef struct packed {
    logic       rs;
    logic       en;
    logic [3:0] nib;
    logic       last;
  } lcd_pin_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [HOLD_W-1:0] cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        opcode;
  logic [7:0]        value;
  logic              row;
  logic [5:0]        col;
  logic              out_valid;
  logic              out_ready;
  logic              reg_select;
  logic              enable;
  logic [3:0]        nibble;
  logic              last;

  lcd_pin_t          pending_pins[$];
  int                error_count = 0;
  int                cycle_count = 0;
  bit                idle_on = 1'b1;
  int                stall_left = 0;

  char_lcd_nibble_writer uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .value      (value),
    .row        (row),
    .col        (col),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .reg_select (reg_select),
    .enable     (enable),
    .nibble     (nibble),
    .last       (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!idle_on) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(1, 11) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    lcd_pin_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_pins.size() == 0) begin
        if (error_count < REPORT_MAX)
          $display("unexpected pin state rs=%0b en=%0b nib=%h last=%0b",
                   reg_select, enable, nibble, last);
        error_count++;
      end else begin
        want = pending_pins.pop_front();
        if (want.rs !== reg_select || want.en !== enable || want.nib !== nibble ||
            want.last !== last) begin
          if (error_count < REPORT_MAX)
            $display("pin state mismatch: expected rs=%0b en=%0b nib=%h last=%0b,",
                     want.rs, want.en, want.nib, want.last,
                     " got rs=%0b en=%0b nib=%h last=%0b",
                     reg_select, enable, nibble, last);
          error_count++;
        end
      end
    end
  end

  task automatic add_byte(ref lcd_pin_t seq[$], input logic rs, input logic [7:0] b);
    seq.push_back('{rs: rs, en: 1'b1, nib: b[7:4], last: 1'b0});
    seq.push_back('{rs: rs, en: 1'b0, nib: b[7:4], last: 1'b0});
    seq.push_back('{rs: rs, en: 1'b1, nib: b[3:0], last: 1'b0});
    seq.push_back('{rs: rs, en: 1'b0, nib: b[3:0], last: 1'b0});
  endtask

  task automatic predict_pins(input logic [1:0] op, input logic [7:0] v, input logic r,
                              input logic [5:0] c);
    lcd_pin_t   seq[$];
    logic [7:0] addr;
    case (op)
      OP_CMD:  add_byte(seq, 1'b0, v);
      OP_DATA: add_byte(seq, 1'b1, v);
      OP_CURSOR: begin
        addr = (r ? LINE1_BASE : LINE0_BASE) + {2'b00, c};
        add_byte(seq, 1'b0, addr);
      end
      default: begin
        for (int i = 0; i < 5; i++)
          add_byte(seq, 1'b0, POWERUP_SEQ[i]);
      end
    endcase
    seq[seq.size() - 1].last = 1'b1;
    foreach (seq[i])
      pending_pins.push_back(seq[i]);
  endtask

  task automatic send_item(input logic [1:0] op, input logic [7:0] v, input logic r,
                           input logic [5:0] c);
    if (idle_on && $urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 11)) @(posedge clk);
    @(posedge clk);
    in_valid <= 1'b1;
    opcode <= op;
    value <= v;
    row <= r;
    col <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_valid <= 1'b0;
    predict_pins(op, v, r, c);
  endtask

  task automatic drain_pins();
    while (pending_pins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_hold(input logic [HOLD_W-1:0] cycles);
    drain_pins();
    cfg_we <= 1'b1;
    cfg_wdata <= cycles;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_item();
    logic [5:0] c;
    c = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(40, 63)) : 6'($urandom_range(0, 39));
    send_item(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), c);
  endtask

  task automatic test_reset_hold();
    send_item(OP_CMD, 8'h5A, 1'b0, 6'd0);
  endtask

  task automatic test_hold_extremes();
    set_hold(HOLD_MAX);
    set_hold(24'd1);
  endtask

  task automatic test_commands();
    send_item(OP_CMD, 8'h00, 1'b1, 6'd63);
    send_item(OP_CMD, 8'hFF, 1'b0, 6'd0);
    send_item(OP_CMD, 8'h96, 1'b1, 6'd21);
  endtask

  task automatic test_data();
    send_item(OP_DATA, 8'h00, 1'b0, 6'd0);
    send_item(OP_DATA, 8'hFF, 1'b1, 6'd63);
    send_item(OP_DATA, 8'hA5, 1'b0, 6'd42);
  endtask

  task automatic test_cursor();
    send_item(OP_CURSOR, 8'hFF, 1'b0, 6'd0);
    send_item(OP_CURSOR, 8'h00, 1'b0, 6'd39);
    send_item(OP_CURSOR, 8'h3C, 1'b1, 6'd0);
    send_item(OP_CURSOR, 8'hC3, 1'b1, 6'd39);
    send_item(OP_CURSOR, 8'h11, 1'b0, 6'd40);
    send_item(OP_CURSOR, 8'h22, 1'b0, 6'd63);
    send_item(OP_CURSOR, 8'h44, 1'b1, 6'd63);
  endtask

  task automatic test_powerup();
    send_item(OP_DATA, 8'hFF, 1'b0, 6'd0);
    send_item(OP_POWERUP, 8'hFF, 1'b1, 6'd63);
    send_item(OP_POWERUP, 8'h00, 1'b0, 6'd0);
  endtask

  task automatic test_hold_zero();
    set_hold(24'd0);
    send_item(OP_DATA, 8'h3E, 1'b0, 6'd0);
    send_item(OP_POWERUP, 8'h81, 1'b1, 6'd17);
    send_item(OP_CURSOR, 8'h00, 1'b1, 6'd5);
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 4; phase++) begin
      set_hold(24'($urandom_range(1, 6)));
      for (int k = 0; k < 15; k++) begin
        send_random_item();
        if (phase == 1 && k == 10)
          drain_pins();
      end
    end
  endtask

  task automatic test_no_idle_tail();
    set_hold(24'd2);
    idle_on = 1'b0;
    for (int k = 0; k < 20; k++)
      send_random_item();
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    opcode <= OP_CMD;
    value <= '0;
    row <= 1'b0;
    col <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_hold();
    test_hold_extremes();
    test_commands();
    test_data();
    test_cursor();
    test_powerup();
    test_hold_zero();
    test_random();
    test_no_idle_tail();

    drain_pins();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/lcdnw_pkg.sv
rtl/lcdnw_ctrl.sv
rtl/lcdnw_dp.sv
rtl/char_lcd_nibble_writer.sv
rtl/lcdnw_checker.sv
tb/sv/tb_char_lcd_nibble_writer.sv
